// ----- design/sdre_pkg.sv -----
// Shared types and constants for the scanline dark run extractor.
// No dependencies.
package sdre_pkg;

    localparam int MAX_WIDTH = 256;

    localparam int PIX_W  = 8;
    localparam int LVL_W  = 8;
    localparam int ROWW_W = 9;
    localparam int OUT_W  = 9;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 9;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EFFW_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (EFFW_W > ROWW_W) ? EFFW_W : ROWW_W;

    localparam logic [LVL_W-1:0]  BLACK_RESET = LVL_W'(8'h0A);
    localparam logic [LVL_W-1:0]  WHITE_RESET = LVL_W'(8'hF0);
    localparam logic [ROWW_W-1:0] ROWW_RESET  = ROWW_W'(70);

    localparam logic [CMP_W-1:0] MIN_W_C = CMP_W'(2);
    localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

    typedef enum logic [IDX_W-1:0] {
        REG_BLACK_LEVEL = 2'd0,
        REG_WHITE_LEVEL = 2'd1,
        REG_ROW_WIDTH   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [LVL_W-1:0]  black_level;
        logic [LVL_W-1:0]  white_level;
        logic [ROWW_W-1:0] row_width;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [COL_W-1:0] run_start;
        logic             run_open;
    } state_t;

    typedef struct packed {
        logic             emit;
        logic [OUT_W-1:0] seg_start;
        logic [OUT_W-1:0] seg_end;
        logic             seg_valid;
        logic             row_done;
    } result_t;

endpackage

// ----- design/sdre_step.sv -----
// Per-pixel run detection: classifies one pixel, updates the run state and
// forms the centered result. Depends on sdre_pkg.
module sdre_step (
    input  sdre_pkg::cfg_t                 cfg,
    input  sdre_pkg::state_t               state,
    input  logic [sdre_pkg::PIX_W-1:0]     pixel,
    output sdre_pkg::state_t               state_next,
    output sdre_pkg::result_t              result
);
    import sdre_pkg::*;

    logic [CMP_W-1:0] row_w_ext;
    logic [CMP_W-1:0] eff_w;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] col_plus1;
    logic [CMP_W-1:0] start_a_ext;
    logic [COL_W:0]   start_plus1;
    logic [COL_W:0]   col_wide;
    logic             last;
    logic             dark;
    logic             light;
    logic             open_a;
    logic [COL_W-1:0] start_a;
    logic             close_light;
    logic             close_last;
    logic             have_run;
    logic [CMP_W-1:0] pos_s;
    logic [CMP_W-1:0] pos_e;
    logic [OUT_W-1:0] half_w;

    assign row_w_ext = CMP_W'(cfg.row_width);
    assign eff_w     = (row_w_ext < MIN_W_C) ? MIN_W_C :
                       (row_w_ext > MAX_W_C) ? MAX_W_C : row_w_ext;
    assign half_w    = OUT_W'(eff_w >> 1);

    assign col_ext   = CMP_W'(state.column);
    assign col_plus1 = col_ext + CMP_W'(1);
    assign last      = (col_plus1 >= eff_w);

    assign dark  = (pixel <= cfg.black_level);
    assign light = (pixel >= cfg.white_level);

    assign col_wide    = {1'b0, state.column};
    assign start_plus1 = {1'b0, state.run_start} + (COL_W+1)'(1);

    // dark test has priority over light
    always_comb
    begin
        open_a      = state.run_open;
        start_a     = state.run_start;
        close_light = 1'b0;
        if (dark)
        begin
            if (!state.run_open)
            begin
                open_a  = 1'b1;
                start_a = state.column;
            end
        end
        else if (light)
        begin
            if (state.run_open && (col_wide > start_plus1))
            begin
                close_light = 1'b1;
                open_a      = 1'b0;
            end
        end
    end

    assign start_a_ext = CMP_W'(start_a);
    assign close_last  = last && open_a && (eff_w > (start_a_ext + CMP_W'(1)));
    assign have_run    = close_light || close_last;

    always_comb
    begin
        if (close_last)
        begin
            pos_s = start_a_ext;
            pos_e = eff_w;
        end
        else
        begin
            pos_s = CMP_W'(state.run_start);
            pos_e = col_ext;
        end
    end

    always_comb
    begin
        if (last)
        begin
            state_next.column    = '0;
            state_next.run_start = '0;
            state_next.run_open  = 1'b0;
        end
        else
        begin
            state_next.column    = state.column + COL_W'(1);
            state_next.run_start = start_a;
            state_next.run_open  = open_a;
        end
    end

    assign result.emit      = have_run || last;
    assign result.seg_start = have_run ? (OUT_W'(pos_s) - half_w) : '0;
    assign result.seg_end   = have_run ? (OUT_W'(pos_e) - half_w) : '0;
    assign result.seg_valid = have_run;
    assign result.row_done  = last;

endmodule

// ----- design/scanline_dark_run_extractor_unit.sv -----
// Scanline dark run extractor, top level: input register, run logic, output register.
// Depends on sdre_pkg and sdre_step.
// Path: a pixel's result passes through the input register and then the output register.
// Throughput: one pixel per cycle; the input stalls only while the input register and
// the output register are both full and the output is stalled.
// Reset clears the run state and valid flags and loads the defaults (10, 240, 70).
module scanline_dark_run_extractor_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sdre_pkg::PIX_W-1:0]      pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [sdre_pkg::OUT_W-1:0] seg_start,
    output logic signed [sdre_pkg::OUT_W-1:0] seg_end,
    output logic                            seg_valid,
    output logic                            row_done,
    input  logic                            cfg_write,
    input  logic [sdre_pkg::IDX_W-1:0]      cfg_index,
    input  logic [sdre_pkg::CFG_W-1:0]      cfg_data
);
    import sdre_pkg::*;

    cfg_t             cfg_reg;
    state_t           state_reg;
    state_t           state_next;
    result_t          result;
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] seg_start_reg;
    logic [OUT_W-1:0] seg_end_reg;
    logic             seg_valid_reg;
    logic             row_done_reg;
    logic             advance;
    logic             s1_fire;

    assign advance  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.black_level <= BLACK_RESET;
            cfg_reg.white_level <= WHITE_RESET;
            cfg_reg.row_width   <= ROWW_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_BLACK_LEVEL: cfg_reg.black_level <= cfg_data[LVL_W-1:0];
                REG_WHITE_LEVEL: cfg_reg.white_level <= cfg_data[LVL_W-1:0];
                REG_ROW_WIDTH:   cfg_reg.row_width   <= cfg_data[ROWW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_pixel_reg <= pixel;
        end
    end

    sdre_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .pixel      (s1_pixel_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_fire && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && result.emit)
        begin
            seg_start_reg <= result.seg_start;
            seg_end_reg   <= result.seg_end;
            seg_valid_reg <= result.seg_valid;
            row_done_reg  <= result.row_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign seg_start = $signed(seg_start_reg);
    assign seg_end   = $signed(seg_end_reg);
    assign seg_valid = seg_valid_reg;
    assign row_done  = row_done_reg;

    logic signed [OUT_W:0] seg_len;
    assign seg_len = $signed({seg_end_reg[OUT_W-1], seg_end_reg})
                     - $signed({seg_start_reg[OUT_W-1], seg_start_reg});

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_row_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && result.row_done) |=> (state_reg.column == '0 && !state_reg.run_open))
        else $error("row end did not reset column and run state");

    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && seg_valid_reg) |-> (seg_len > $signed((OUT_W+1)'(1))))
        else $error("reported run is not longer than one pixel");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !seg_valid_reg)
            |-> (row_done_reg && seg_start_reg == '0 && seg_end_reg == '0))
        else $error("bare result is not a clean row marker");

    a_emit_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && result.emit) |=> out_valid_reg)
        else $error("result lost between run logic and output register");

endmodule
